FILE: rtl/fat12_pkg.sv
// Shared types and constants for the FAT12 allocation table engine.
package fat12_pkg;

   // Byte address width that covers the largest table (4096 entries, 6144 bytes).
   localparam int ABW = 13;
   localparam int EW  = 12;
   localparam int BW  = 8;
   localparam int FW  = 3;

   localparam logic [EW-1:0] LIMIT_RESET = 12'd2847;
   localparam logic [EW-1:0] WALK_FIRST  = 12'd2;

   localparam logic [BW-1:0] NIB_HI_MASK = 8'hF0;
   localparam logic [BW-1:0] NIB_LO_MASK = 8'h0F;
   localparam logic [BW-1:0] BYTE_MASK   = 8'hFF;

   typedef enum logic [FW-1:0] {
      FUNC_READ_ENTRY  = 3'd0,
      FUNC_WRITE_ENTRY = 3'd1,
      FUNC_FIND_FREE   = 3'd2,
      FUNC_COUNT_FREE  = 3'd3,
      FUNC_LOAD_BYTE   = 3'd4,
      FUNC_READ_BYTE   = 3'd5
   } func_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_RD_LO,
      S_RD_HI,
      S_EVAL,
      S_WR_LO,
      S_WR_HI,
      S_BYTE_WR,
      S_BYTE_RD,
      S_BYTE_DATA,
      S_FIN
   } state_type;

   typedef enum logic [1:0] {
      RD_BASE,
      RD_BASE1,
      RD_NEXT,
      RD_BYTE
   } rd_sel_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_CLEAR,
      WR_LO,
      WR_HI,
      WR_BYTE
   } wr_sel_type;

   typedef struct packed {
      logic [FW-1:0]  func;
      logic [EW-1:0]  entry_index;
      logic [EW-1:0]  entry_value;
      logic [ABW-1:0] byte_index;
      logic [BW-1:0]  byte_value;
   } req_type;

   typedef struct packed {
      logic [EW-1:0] result_entry;
      logic          found;
      logic [EW-1:0] free_count;
      logic [BW-1:0] result_byte;
   } rsp_type;

   typedef struct packed {
      logic       capture;
      rd_sel_type rd_sel;
      wr_sel_type wr_sel;
      logic       lo_load;
      logic       hi_load;
      logic       advance;
      logic       tally;
      logic       finish;
      logic       hit;
      logic       clear_step;
   } dp_cmd_type;

   typedef struct packed {
      logic          [FW-1:0] req_func;
      logic          req_walk_empty;
      logic          [FW-1:0] func;
      logic          clear_done;
      logic          entry_ok;
      logic          entry_zero;
      logic          at_last;
   } dp_status_type;

endpackage

FILE: rtl/fat12_dpath.sv
// Datapath: packed table memory, entry assembly and update, walk counters, result register.
module fat12_dpath
   import fat12_pkg::*;
#(
   parameter int MAX_ENTRIES = 4096
) (
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   input  logic          csr_valid,
   input  logic [EW-1:0] csr_data,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output logic          rsp_valid,
   output rsp_type       rsp_data
);

   localparam int TABLE_SIZE = (MAX_ENTRIES * 3) / 2;
   localparam int AW = $clog2(TABLE_SIZE);
   localparam logic [ABW-1:0] TABLE_LIMIT = ABW'(TABLE_SIZE);
   localparam logic [EW:0]    ENTRY_LIMIT = (EW+1)'(MAX_ENTRIES);
   localparam logic [AW-1:0]  CLEAR_LAST  = AW'(TABLE_SIZE - 1);

   logic [BW-1:0] mem [TABLE_SIZE];

   logic [EW-1:0]  limit_ff;
   logic [AW-1:0]  clr_ff;
   logic [FW-1:0]  func_ff;
   logic [EW-1:0]  idx_ff;
   logic [EW-1:0]  val_ff;
   logic [ABW-1:0] bidx_ff;
   logic [BW-1:0]  bval_ff;
   logic [EW-1:0]  last_ff;
   logic [EW-1:0]  count_ff;
   logic [BW-1:0]  lo_ff;
   logic [BW-1:0]  hi_ff;
   logic [BW-1:0]  rdata_ff;
   logic           rd_ok_ff;
   logic           rsp_valid_ff;
   rsp_type        rsp_data_ff;

   logic [EW-1:0]  count_in;
   rsp_type        rsp_data_in;
   logic [EW:0]    lim_find;
   logic [EW-1:0]  lim_count;
   logic           req_walk;
   logic           walk_empty;
   logic [EW-1:0]  walk_last;
   logic [EW-1:0]  idx_next;
   logic [ABW-1:0] base;
   logic [ABW-1:0] base1;
   logic [ABW-1:0] base_next;
   logic [ABW-1:0] raddr;
   logic [ABW-1:0] waddr;
   logic [BW-1:0]  wdata;
   logic           we;
   logic [BW-1:0]  rdata_eff;
   logic           entry_ok;
   logic [EW-1:0]  entry_val;
   logic [BW-1:0]  new_lo;
   logic [BW-1:0]  new_hi;

   // Entry n starts at byte n + n/2.
   assign idx_next  = idx_ff + 1'b1;
   assign base      = ABW'(idx_ff) + ABW'(idx_ff[EW-1:1]);
   assign base1     = base + 1'b1;
   assign base_next = ABW'(idx_next) + ABW'(idx_next[EW-1:1]);
   assign entry_ok  = ({1'b0, idx_ff} < ENTRY_LIMIT) && (base1 < TABLE_LIMIT);
   assign rdata_eff = rd_ok_ff ? rdata_ff : '0;

   always_comb begin
      if (!entry_ok) begin
         entry_val = '0;
      end else if (idx_ff[0]) begin
         entry_val = {rdata_eff, lo_ff[7:4]};
      end else begin
         entry_val = {rdata_eff[3:0], lo_ff};
      end
   end

   // Keep the nibble that belongs to the neighbor entry.
   always_comb begin
      if (idx_ff[0]) begin
         new_lo = (lo_ff & NIB_LO_MASK) | ({val_ff[3:0], 4'h0} & NIB_HI_MASK);
         new_hi = val_ff[11:4] & BYTE_MASK;
      end else begin
         new_lo = val_ff[7:0] & BYTE_MASK;
         new_hi = (hi_ff & NIB_HI_MASK) | ({4'h0, val_ff[11:8]} & NIB_LO_MASK);
      end
   end

   // Walk bounds: find covers 2 .. limit-1, count covers 2 .. limit.
   assign lim_find  = ({1'b0, limit_ff} < ENTRY_LIMIT) ? {1'b0, limit_ff} : ENTRY_LIMIT;
   assign lim_count = ({1'b0, limit_ff} < ENTRY_LIMIT - 1'b1) ? limit_ff
                      : EW'(ENTRY_LIMIT - 1'b1);
   assign req_walk  = (req_data.func == FUNC_FIND_FREE) || (req_data.func == FUNC_COUNT_FREE);

   always_comb begin
      if (req_data.func == FUNC_FIND_FREE) begin
         walk_empty = lim_find <= (EW+1)'(WALK_FIRST);
         walk_last  = EW'(lim_find - 1'b1);
      end else begin
         walk_empty = lim_count < WALK_FIRST;
         walk_last  = lim_count;
      end
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_BASE:  raddr = base;
         RD_BASE1: raddr = base1;
         RD_NEXT:  raddr = base_next;
         RD_BYTE:  raddr = bidx_ff;
         default:  raddr = base;
      endcase
   end

   always_comb begin
      waddr = ABW'(clr_ff);
      wdata = '0;
      case (cmd.wr_sel)
         WR_CLEAR: begin
            waddr = ABW'(clr_ff);
            wdata = '0;
         end
         WR_LO: begin
            waddr = base;
            wdata = new_lo;
         end
         WR_HI: begin
            waddr = base1;
            wdata = new_hi;
         end
         WR_BYTE: begin
            waddr = bidx_ff;
            wdata = bval_ff;
         end
         default: begin
            waddr = ABW'(clr_ff);
            wdata = '0;
         end
      endcase
      we = (cmd.wr_sel != WR_NONE) && (waddr < TABLE_LIMIT);
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr[AW-1:0]] <= wdata;
      end
      rdata_ff <= mem[raddr[AW-1:0]];
      rd_ok_ff <= raddr < TABLE_LIMIT;
   end

   assign count_in = count_ff + EW'(cmd.tally && (entry_val == '0));

   always_comb begin
      rsp_data_in = '0;
      case (func_ff)
         FUNC_READ_ENTRY: rsp_data_in.result_entry = entry_val;
         FUNC_FIND_FREE: begin
            rsp_data_in.found        = cmd.hit;
            rsp_data_in.result_entry = cmd.hit ? idx_ff : '0;
         end
         FUNC_COUNT_FREE: rsp_data_in.free_count  = count_in;
         FUNC_READ_BYTE:  rsp_data_in.result_byte = rdata_eff;
         default:         rsp_data_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            limit_ff <= csr_data;
         end
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + 1'b1;
         end
         rsp_valid_ff <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= req_data.func;
         idx_ff   <= req_walk ? WALK_FIRST : req_data.entry_index;
         val_ff   <= req_data.entry_value;
         bidx_ff  <= req_data.byte_index;
         bval_ff  <= req_data.byte_value;
         last_ff  <= walk_last;
         count_ff <= '0;
      end else begin
         if (cmd.advance) begin
            idx_ff <= idx_next;
         end
         if (cmd.tally) begin
            count_ff <= count_in;
         end
      end
      if (cmd.lo_load) begin
         lo_ff <= rdata_eff;
      end
      if (cmd.hi_load) begin
         hi_ff <= rdata_eff;
      end
      if (cmd.finish) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_comb begin
      status.req_func       = req_data.func;
      status.req_walk_empty = walk_empty;
      status.func           = func_ff;
      status.clear_done     = clr_ff == CLEAR_LAST;
      status.entry_ok       = entry_ok;
      status.entry_zero     = entry_val == '0;
      status.at_last        = idx_ff == last_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/fat12_ctrl.sv
// Controller: sequences table clearing, entry access, table walks and raw byte access.
module fat12_ctrl
   import fat12_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          busy
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd.capture    = 1'b0;
      cmd.rd_sel     = RD_BASE;
      cmd.wr_sel     = WR_NONE;
      cmd.lo_load    = 1'b0;
      cmd.hi_load    = 1'b0;
      cmd.advance    = 1'b0;
      cmd.tally      = 1'b0;
      cmd.finish     = 1'b0;
      cmd.hit        = 1'b0;
      cmd.clear_step = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.wr_sel     = WR_CLEAR;
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               case (status.req_func)
                  FUNC_READ_ENTRY,
                  FUNC_WRITE_ENTRY: state_in = S_RD_LO;
                  FUNC_FIND_FREE,
                  FUNC_COUNT_FREE:  state_in = status.req_walk_empty ? S_FIN : S_RD_LO;
                  FUNC_LOAD_BYTE:   state_in = S_BYTE_WR;
                  FUNC_READ_BYTE:   state_in = S_BYTE_RD;
                  default:          state_in = S_FIN;
               endcase
            end
         end
         S_RD_LO: begin
            cmd.rd_sel = RD_BASE;
            state_in   = S_RD_HI;
         end
         S_RD_HI: begin
            cmd.rd_sel  = RD_BASE1;
            cmd.lo_load = 1'b1;
            state_in    = S_EVAL;
         end
         S_EVAL: begin
            cmd.hi_load = 1'b1;
            case (status.func)
               FUNC_WRITE_ENTRY: begin
                  if (status.entry_ok) begin
                     state_in = S_WR_LO;
                  end else begin
                     cmd.finish = 1'b1;
                     state_in   = S_IDLE;
                  end
               end
               FUNC_FIND_FREE: begin
                  if (status.entry_zero || status.at_last) begin
                     cmd.hit    = status.entry_zero;
                     cmd.finish = 1'b1;
                     state_in   = S_IDLE;
                  end else begin
                     cmd.advance = 1'b1;
                     cmd.rd_sel  = RD_NEXT;
                     state_in    = S_RD_HI;
                  end
               end
               FUNC_COUNT_FREE: begin
                  cmd.tally = 1'b1;
                  if (status.at_last) begin
                     cmd.finish = 1'b1;
                     state_in   = S_IDLE;
                  end else begin
                     cmd.advance = 1'b1;
                     cmd.rd_sel  = RD_NEXT;
                     state_in    = S_RD_HI;
                  end
               end
               default: begin
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end
            endcase
         end
         S_WR_LO: begin
            cmd.wr_sel = WR_LO;
            state_in   = S_WR_HI;
         end
         S_WR_HI: begin
            cmd.wr_sel = WR_HI;
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         S_BYTE_WR: begin
            cmd.wr_sel = WR_BYTE;
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         S_BYTE_RD: begin
            cmd.rd_sel = RD_BYTE;
            state_in   = S_BYTE_DATA;
         end
         S_BYTE_DATA: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = state_ff != S_IDLE;

endmodule

FILE: rtl/fat12_table_engine.sv
// Top level of the FAT12 allocation table engine.
//
// The engine keeps a FAT12 table as packed bytes (two 12-bit entries in every three
// bytes) in a single-port-write, registered-read byte memory of 3*MAX_ENTRIES/2 bytes.
// Issue a command by raising start with req_data while busy is low; the transfer
// happens at that clock edge. Every command returns exactly one result: rsp_valid is
// high for exactly one cycle with rsp_data, and the receiver cannot stall it, so
// capture it on that cycle. Fields that the operation does not produce read as zero.
// The command sequences are set by the memory having one read port and one registered
// read per cycle: load byte writes one byte, read byte reads one, read entry reads two,
// and write entry reads two, then, if the entry lies in the table, writes both bytes of
// the shared nibble pair; find free and count free read two bytes per entry walked, and
// an empty range returns without a table read.
// After reset the engine clears the table one byte per cycle, all 3*MAX_ENTRIES/2 bytes
// (6144 at the default size), and holds busy high until that pass completes.
// cluster_limit is written through csr_valid/csr_data at any time (csr_ready is
// always high); write it only while the engine is idle.
module fat12_table_engine
   import fat12_pkg::*;
#(
   parameter int MAX_ENTRIES = 4096
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  req_type       req_data,
   output logic          rsp_valid,
   output rsp_type       rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [EW-1:0] csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // The limit register takes every transfer on the config channel.
   assign csr_ready = 1'b1;

   fat12_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   fat12_dpath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the FAT12 allocation table engine.
module tb_top;
   import fat12_pkg::*;

   // Table geometry at the default size: 4096 entries packed into 6144 bytes.
   localparam int N_ENTRIES   = 4096;
   localparam int TBL_BYTES   = (N_ENTRIES * 3) / 2;
   localparam int STALL_LIMIT = 50000;
   localparam int IDLE_PCT    = 37;
   localparam int N_PHASES    = 16;
   localparam int RAND_ITEMS  = 56;
   localparam int WALK_CAP    = 3;

   // Function codes the package leaves unnamed; the engine must ignore both.
   localparam logic [FW-1:0] FUNC_SPARE_A = 3'd6;
   localparam logic [FW-1:0] FUNC_SPARE_B = 3'd7;

   // One directed row: the command, and the reply where it is obvious by inspection.
   typedef struct packed {
      logic [FW-1:0]  func;
      logic [EW-1:0]  eidx;
      logic [EW-1:0]  eval;
      logic [ABW-1:0] bidx;
      logic [BW-1:0]  bval;
      logic           typed;
      logic [EW-1:0]  x_entry;
      logic           x_found;
      logic [EW-1:0]  x_count;
      logic [BW-1:0]  x_byte;
   } dir_row_type;

   localparam int N_DIR = 26;

   // Rows left untyped are checked against the table model below.
   localparam dir_row_type DIR_ROWS [N_DIR] = '{
      // fresh table after the clearing pass
      '{FUNC_READ_ENTRY,  12'd0,    12'd0,    13'd0,    8'd0,   1'b1, 12'd0, 1'b0, 12'd0, 8'd0},
      '{FUNC_READ_ENTRY,  12'd4095, 12'd0,    13'd0,    8'd0,   1'b1, 12'd0, 1'b0, 12'd0, 8'd0},
      '{FUNC_READ_BYTE,   12'd0,    12'd0,    13'd6143, 8'd0,   1'b1, 12'd0, 1'b0, 12'd0, 8'd0},
      '{FUNC_FIND_FREE,   12'd0,    12'd0,    13'd0,    8'd0,   1'b1, 12'd2, 1'b1, 12'd0, 8'd0},
      '{FUNC_COUNT_FREE,  12'd0,    12'd0,    13'd0,    8'd0,   1'b1, 12'd0, 1'b0, 12'd2846,
        8'd0},
      // raw byte access at the top of the table and past its end
      '{FUNC_LOAD_BYTE,   12'd0,    12'd0,    13'd6143, 8'hFF,  1'b1, 12'd0, 1'b0, 12'd0, 8'd0},
      '{FUNC_READ_BYTE,   12'd0,    12'd0,    13'd6143, 8'd0,   1'b1, 12'd0, 1'b0, 12'd0, 8'hFF},
      '{FUNC_LOAD_BYTE,   12'd0,    12'd0,    13'd8191, 8'hAA,  1'b1, 12'd0, 1'b0, 12'd0, 8'd0},
      '{FUNC_READ_BYTE,   12'd0,    12'd0,    13'd8191, 8'd0,   1'b1, 12'd0, 1'b0, 12'd0, 8'd0},
      '{FUNC_READ_BYTE,   12'd0,    12'd0,    13'd6144, 8'd0,   1'b1, 12'd0, 1'b0, 12'd0, 8'd0},
      // last odd entry now sees the loaded top byte
      '{FUNC_READ_ENTRY,  12'd4095, 12'd0,    13'd0,    8'd0,   1'b0, 12'd0, 1'b0, 12'd0, 8'd0},
      '{FUNC_WRITE_ENTRY, 12'd4095, 12'hFFF,  13'd0,    8'd0,   1'b1, 12'd0, 1'b0, 12'd0, 8'd0},
      '{FUNC_WRITE_ENTRY, 12'd4094, 12'h000,  13'd0,    8'd0,   1'b1, 12'd0, 1'b0, 12'd0, 8'd0},
      '{FUNC_READ_ENTRY,  12'd4094, 12'd0,    13'd0,    8'd0,   1'b0, 12'd0, 1'b0, 12'd0, 8'd0},
      // even/odd pair sharing the middle byte
      '{FUNC_WRITE_ENTRY, 12'd2,    12'hABC,  13'd0,    8'd0,   1'b1, 12'd0, 1'b0, 12'd0, 8'd0},
      '{FUNC_WRITE_ENTRY, 12'd3,    12'h123,  13'd0,    8'd0,   1'b1, 12'd0, 1'b0, 12'd0, 8'd0},
      '{FUNC_READ_BYTE,   12'd0,    12'd0,    13'd3,    8'd0,   1'b0, 12'd0, 1'b0, 12'd0, 8'd0},
      '{FUNC_READ_BYTE,   12'd0,    12'd0,    13'd4,    8'd0,   1'b0, 12'd0, 1'b0, 12'd0, 8'd0},
      '{FUNC_READ_BYTE,   12'd0,    12'd0,    13'd5,    8'd0,   1'b0, 12'd0, 1'b0, 12'd0, 8'd0},
      '{FUNC_READ_ENTRY,  12'd3,    12'd0,    13'd0,    8'd0,   1'b0, 12'd0, 1'b0, 12'd0, 8'd0},
      '{FUNC_WRITE_ENTRY, 12'd4,    12'hFFF,  13'd0,    8'd0,   1'b1, 12'd0, 1'b0, 12'd0, 8'd0},
      '{FUNC_FIND_FREE,   12'd0,    12'd0,    13'd0,    8'd0,   1'b0, 12'd0, 1'b0, 12'd0, 8'd0},
      '{FUNC_COUNT_FREE,  12'd0,    12'd0,    13'd0,    8'd0,   1'b0, 12'd0, 1'b0, 12'd0, 8'd0},
      // unused codes with every field at its maximum: no effect, all-zero reply
      '{FUNC_SPARE_A,     12'hFFF,  12'hFFF,  13'h1FFF, 8'hFF,  1'b1, 12'd0, 1'b0, 12'd0, 8'd0},
      '{FUNC_SPARE_B,     12'hFFF,  12'hFFF,  13'h1FFF, 8'hFF,  1'b1, 12'd0, 1'b0, 12'd0, 8'd0},
      '{FUNC_READ_ENTRY,  12'd2,    12'd0,    13'd0,    8'd0,   1'b0, 12'd0, 1'b0, 12'd0, 8'd0}
   };

   logic          clock;
   logic          reset;
   logic          start;
   logic          busy;
   req_type       req_data;
   logic          rsp_valid;
   rsp_type       rsp_data;
   logic          csr_valid;
   logic          csr_ready;
   logic [EW-1:0] csr_data;

   // Shadow copy of the engine's table and its limit register.
   logic [BW-1:0] fat_bytes [TBL_BYTES];
   logic [EW-1:0] fat_limit;

   // Replies owed by the engine, oldest first.
   rsp_type       fat_replies [$];
   int            mismatch_count;
   int            stall_cycles;
   int            walks_in_phase;

   fat12_table_engine u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Entry n sits at byte 3n/2: even entries own the low nibble of the next byte,
   // odd entries own the high nibble of their first byte.
   function automatic logic [EW-1:0] entry_get(logic [EW-1:0] n);
      int            a;
      logic [BW-1:0] lo;
      logic [BW-1:0] hi;
      a  = (3 * int'(n)) / 2;
      lo = fat_bytes[a];
      hi = fat_bytes[a + 1];
      if (n[0]) begin
         return {hi, lo[7:4]};
      end
      return {hi[3:0], lo};
   endfunction

   function automatic void entry_put(logic [EW-1:0] n, logic [EW-1:0] v);
      int a;
      a = (3 * int'(n)) / 2;
      if (n[0]) begin
         fat_bytes[a]     = {v[3:0], fat_bytes[a][3:0]};
         fat_bytes[a + 1] = v[11:4];
      end else begin
         fat_bytes[a]     = v[7:0];
         fat_bytes[a + 1] = {fat_bytes[a + 1][7:4], v[11:8]};
      end
   endfunction

   // Apply one command to the shadow table and return the reply it produces.
   function automatic rsp_type fat_execute(req_type r);
      rsp_type o;
      int      i;
      int      last;
      o = '0;
      case (r.func)
         FUNC_READ_ENTRY:  o.result_entry = entry_get(r.entry_index);
         FUNC_WRITE_ENTRY: entry_put(r.entry_index, r.entry_value);
         FUNC_FIND_FREE: begin
            // search 2 .. limit-1, stop at the first zero entry
            last = (int'(fat_limit) > N_ENTRIES) ? N_ENTRIES : int'(fat_limit);
            i = 2;
            while (i < last && !o.found) begin
               if (entry_get(EW'(i)) == '0) begin
                  o.result_entry = EW'(i);
                  o.found        = 1'b1;
               end
               i++;
            end
         end
         FUNC_COUNT_FREE: begin
            // count 2 .. limit, clipped at the last entry
            last = (int'(fat_limit) > N_ENTRIES - 1) ? N_ENTRIES - 1 : int'(fat_limit);
            for (i = 2; i <= last; i++) begin
               if (entry_get(EW'(i)) == '0) o.free_count = o.free_count + 1'b1;
            end
         end
         FUNC_LOAD_BYTE: begin
            if (int'(r.byte_index) < TBL_BYTES) fat_bytes[r.byte_index] = r.byte_value;
         end
         FUNC_READ_BYTE: begin
            if (int'(r.byte_index) < TBL_BYTES) o.result_byte = fat_bytes[r.byte_index];
         end
         default: ;
      endcase
      return o;
   endfunction

   // Present one command, hold it until the engine takes it, then record the reply
   // it owes: the typed one if given, else the shadow model's.
   task automatic issue(input req_type r, input bit typed, input rsp_type want,
                        input bit idle_on);
      rsp_type got;
      while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      // busy read right after the edge is still the value the edge sampled
      do @(posedge clock); while (busy);
      got = fat_execute(r);
      fat_replies.push_back(typed ? want : got);
   endtask

   // Write the cluster limit once the engine has drained every owed reply.
   task automatic set_limit(input logic [EW-1:0] v);
      start <= 1'b0;
      while (fat_replies.size() != 0 || busy) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      fat_limit = v;
   endtask

   // Build one random command. Entry and byte indexes cluster around the walked
   // range so that writes actually fill it, with a share spread over everything.
   function automatic req_type make_item(int lim);
      req_type r;
      int      roll;
      int      span;
      int      bspan;
      span  = (lim + 3 > N_ENTRIES - 1) ? N_ENTRIES - 1 : ((lim + 3 < 8) ? 8 : lim + 3);
      bspan = (3 * span) / 2 + 3;
      roll  = $urandom_range(0, 99);
      if (roll < 20)      r.func = FUNC_READ_ENTRY;
      else if (roll < 50) r.func = FUNC_WRITE_ENTRY;
      else if (roll < 60) r.func = FUNC_FIND_FREE;
      else if (roll < 68) r.func = FUNC_COUNT_FREE;
      else if (roll < 80) r.func = FUNC_LOAD_BYTE;
      else if (roll < 95) r.func = FUNC_READ_BYTE;
      else                r.func = (roll[0]) ? FUNC_SPARE_A : FUNC_SPARE_B;
      // walks over a wide limit are long: allow at most WALK_CAP of them per phase
      if (r.func == FUNC_FIND_FREE || r.func == FUNC_COUNT_FREE) begin
         if (lim > 256 && walks_in_phase >= WALK_CAP) r.func = FUNC_READ_ENTRY;
         else walks_in_phase++;
      end
      r.entry_index = ($urandom_range(0, 4) != 0) ? EW'($urandom_range(0, span))
                                                  : EW'($urandom_range(0, 4095));
      roll = $urandom_range(0, 9);
      if (roll < 2)       r.entry_value = '0;
      else if (roll == 2) r.entry_value = '1;
      else                r.entry_value = EW'($urandom_range(1, 4095));
      r.byte_index = ($urandom_range(0, 3) != 0) ? ABW'($urandom_range(0, bspan))
                                                 : ABW'($urandom_range(0, 8191));
      r.byte_value = BW'($urandom_range(0, 255));
      return r;
   endfunction

   // One setting of the limit: for a limit of 3 to 128, fill the walked range with nonzero
   // entries so the search runs dry and probe it; then mix in random traffic.
   task automatic run_phase(input int lim, input bit idle_on);
      req_type r;
      int      i;
      set_limit(EW'(lim));
      walks_in_phase = 0;
      if (lim >= 3 && lim <= 128) begin
         for (i = 2; i < lim; i++) begin
            r = '0;
            r.func        = FUNC_WRITE_ENTRY;
            r.entry_index = EW'(i);
            r.entry_value = EW'($urandom_range(1, 4095));
            issue(r, 1'b0, '0, idle_on);
         end
         r = '0;
         r.func = FUNC_FIND_FREE;
         issue(r, 1'b0, '0, idle_on);
         r.func = FUNC_COUNT_FREE;
         issue(r, 1'b0, '0, idle_on);
      end
      for (i = 0; i < RAND_ITEMS; i++) begin
         r = make_item(lim);
         issue(r, 1'b0, '0, idle_on);
      end
   endtask

   // Compare every reply against the oldest owed one, field by field.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (fat_replies.size() == 0) begin
            $error("unexpected reply: entry %0h found %0b count %0d byte %0h",
                   rsp_data.result_entry, rsp_data.found, rsp_data.free_count,
                   rsp_data.result_byte);
            mismatch_count++;
         end else begin
            want = fat_replies.pop_front();
            if (rsp_data.result_entry !== want.result_entry) begin
               $error("result_entry: expected %0h, got %0h",
                      want.result_entry, rsp_data.result_entry);
               mismatch_count++;
            end
            if (rsp_data.found !== want.found) begin
               $error("found: expected %0b, got %0b", want.found, rsp_data.found);
               mismatch_count++;
            end
            if (rsp_data.free_count !== want.free_count) begin
               $error("free_count: expected %0d, got %0d",
                      want.free_count, rsp_data.free_count);
               mismatch_count++;
            end
            if (rsp_data.result_byte !== want.result_byte) begin
               $error("result_byte: expected %0h, got %0h",
                      want.result_byte, rsp_data.result_byte);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: any transfer on any channel restarts the count. The clearing pass
   // after reset and a full-table count both fit well inside the limit.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      req_type r;
      rsp_type want;
      int      p;
      int      lim;
      reset          = 1'b1;
      start          = 1'b0;
      req_data       = '0;
      csr_valid      = 1'b0;
      csr_data       = '0;
      mismatch_count = 0;
      stall_cycles   = 0;
      walks_in_phase = 0;
      fat_limit      = LIMIT_RESET;
      foreach (fat_bytes[i]) fat_bytes[i] = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table at the reset value of the limit.
      for (p = 0; p < N_DIR; p++) begin
         r.func        = DIR_ROWS[p].func;
         r.entry_index = DIR_ROWS[p].eidx;
         r.entry_value = DIR_ROWS[p].eval;
         r.byte_index  = DIR_ROWS[p].bidx;
         r.byte_value  = DIR_ROWS[p].bval;
         want.result_entry = DIR_ROWS[p].x_entry;
         want.found        = DIR_ROWS[p].x_found;
         want.free_count   = DIR_ROWS[p].x_count;
         want.result_byte  = DIR_ROWS[p].x_byte;
         issue(r, DIR_ROWS[p].typed, want, 1'b1);
      end

      // Sweep the limit: zero, the maximum, the degenerate small values, the reset
      // value, then random small settings. Two phases run back to back with no gaps.
      for (p = 0; p < N_PHASES; p++) begin
         case (p)
            0:       lim = 0;
            1:       lim = 4095;
            2:       lim = 1;
            3:       lim = 2;
            4:       lim = 3;
            5:       lim = int'(LIMIT_RESET);
            default: lim = $urandom_range(4, 120);
         endcase
         run_phase(lim, !(p == 7 || p == 8));
      end
      start <= 1'b0;

      // Drain owed replies, then leave time for stray ones to show up.
      while (fat_replies.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/fat12_pkg.sv
rtl/fat12_dpath.sv
rtl/fat12_ctrl.sv
rtl/fat12_table_engine.sv
tb/tb_top.sv
